/* design/hpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_pkg: shared types and constants for the pursuit block
// Payload structs, register indexes, reset values and the CORDIC angle table.
// ----------------------------------------------------------------------------
package hpp_pkg;

  localparam int CordicSteps = 16;

  localparam logic [0:0] REG_ANGULAR_RATE = 1'b0;
  localparam logic [0:0] REG_LINEAR_RATE  = 1'b1;

  localparam logic [15:0] ANGULAR_RATE_RESET = 16'd18204;
  localparam logic [15:0] LINEAR_RATE_RESET  = 16'd25600;
  localparam logic [19:0] POS_X_RESET        = 20'd102400;
  localparam logic [19:0] POS_Y_RESET        = 20'd76800;
  localparam logic [23:0] HALF_TURN_ACC      = 24'h800000;

  typedef struct packed {
    logic signed [11:0] target_x;
    logic signed [11:0] target_y;
    logic [15:0]        elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] position_x;
    logic signed [19:0] position_y;
    logic [15:0]        heading;
  } out_item_t;

  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] v;
    unique case (i)
      5'd0:  v = 24'd2097152;
      5'd1:  v = 24'd1238021;
      5'd2:  v = 24'd654136;
      5'd3:  v = 24'd332050;
      5'd4:  v = 24'd166669;
      5'd5:  v = 24'd83416;
      5'd6:  v = 24'd41718;
      5'd7:  v = 24'd20860;
      5'd8:  v = 24'd10430;
      5'd9:  v = 24'd5215;
      5'd10: v = 24'd2608;
      5'd11: v = 24'd1304;
      5'd12: v = 24'd652;
      5'd13: v = 24'd326;
      5'd14: v = 24'd163;
      5'd15: v = 24'd81;
      5'd16: v = 24'd41;
      5'd17: v = 24'd20;
      5'd18: v = 24'd10;
      5'd19: v = 24'd5;
      5'd20: v = 24'd3;
      5'd21: v = 24'd1;
      5'd22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/heading_and_position_pursuit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heading_and_position_pursuit: rate-limited turn and travel toward a target
// Sequenced CORDIC bearing, bit-serial square root and a shared serial divider.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. After the input beat is accepted the block
// runs 16 CORDIC iterations for the bearing, a multiply step for the limits
// and the squared distance, 21 square-root steps and a turn step, then two
// divisions (one per axis) on a single restoring divider, each made of a
// start step, 48 quotient bits and a step to pick up the quotient, and last
// loads the output register. When the target is within one step the
// divisions are skipped.
// The input is not ready while an update is in progress; a finished result
// sits in an output register and the next input beat is taken as soon as
// that result has been taken. Configuration writes go straight to the rate
// registers and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module heading_and_position_pursuit
  import hpp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam logic [3:0] S_IDLE = 4'd0, S_CORD = 4'd1, S_MUL = 4'd2, S_SQRT = 4'd3,
                         S_TURN = 4'd4, S_DIVX = 4'd5, S_WX = 4'd6, S_DIVY = 4'd7,
                         S_WY = 4'd8, S_OUT = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [15:0] ar_r, lr_r;
  logic [19:0] px_r, py_r;
  logic [15:0] hd_r;
  out_item_t   od_r;
  logic        ov_r;

  // Working registers.
  logic signed [20:0] dx_r, dy_r;
  logic signed [31:0] cx_r, cy_r;
  logic [23:0] z_r;
  logic [4:0]  it_r;
  logic        zero_r;
  logic [15:0] dt_r;
  logic [15:0] lim_r;
  logic [15:0] step_r;
  logic [41:0] sq_r;    // remaining radicand
  logic [20:0] rt_r;    // root
  logic [4:0]  sqi_r;
  logic [19:0] nx_r;

  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;

  // CORDIC step.
  logic signed [31:0] shy, shx;
  always_comb begin
    shy = cy_r >>> it_r;
    shx = cx_r >>> it_r;
  end

  // Square-root step: two radicand bits per cycle.
  logic [4:0]  sq_k;
  logic [43:0] sq_trial;
  always_comb begin
    sq_k = 5'd20 - sqi_r;
    sq_trial = 44'({rt_r, 2'b01}) << {sq_k, 1'b0};
  end

  // Bearing and turn.
  logic [15:0] bear, err;
  logic signed [16:0] err_s;
  logic [16:0] mag;
  logic [15:0] nh;
  always_comb begin
    bear = zero_r ? 16'd0 : 16'(({8'd0, z_r} + 32'd128) >> 8);
    err = bear - hd_r;
    err_s = (err > 16'd32768) ? ({1'b0, err} - 17'sd65536) : {1'b0, err};
    mag = err_s[16] ? 17'(-err_s) : 17'(err_s);
    if (mag < {1'b0, lim_r}) nh = hd_r + err_s[15:0];
    else if (err_s[16]) nh = hd_r - lim_r;
    else nh = hd_r + lim_r;
  end

  // Offset magnitudes for the distance and the divisions.
  logic [20:0] adx, ady;
  assign adx = dx_r[20] ? 21'(-dx_r) : 21'(dx_r);
  assign ady = dy_r[20] ? 21'(-dy_r) : 21'(dy_r);

  // Division operands: |step*d| + D/2.
  logic [20:0] ad_sel;
  logic [36:0] prod;
  assign ad_sel = (st_r == S_DIVX) ? adx : ady;
  assign prod = 37'(step_r) * 37'(ad_sel);
  assign div_num = 48'(prod) + 48'(rt_r[20:1]);
  assign div_start = (st_r == S_DIVX) || (st_r == S_DIVY);

  hpp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den({3'd0, rt_r}), .done(div_done), .quo(div_quo)
  );

  logic signed [20:0] qs;
  assign qs = (st_r == S_WX ? dx_r[20] : dy_r[20]) ? -21'(div_quo[20:0]) : 21'(div_quo[20:0]);

  logic signed [20:0] txs, tys;
  assign txs = {in_data.target_x[11], in_data.target_x, 8'd0};
  assign tys = {in_data.target_y[11], in_data.target_y, 8'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ar_r <= ANGULAR_RATE_RESET;
      lr_r <= LINEAR_RATE_RESET;
      px_r <= POS_X_RESET;
      py_r <= POS_Y_RESET;
      hd_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ANGULAR_RATE) ar_r <= cfg_data;
        else lr_r <= cfg_data;
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            dx_r <= txs - 21'(signed'(px_r));
            dy_r <= tys - 21'(signed'(py_r));
            if (txs < 21'(signed'(px_r))) begin
              cx_r <= 32'(signed'({(21'(signed'(px_r)) - txs), 8'd0}));
              cy_r <= 32'(signed'({(21'(signed'(py_r)) - tys), 8'd0}));
              z_r <= HALF_TURN_ACC;
            end else begin
              cx_r <= 32'(signed'({(txs - 21'(signed'(px_r))), 8'd0}));
              cy_r <= 32'(signed'({(tys - 21'(signed'(py_r))), 8'd0}));
              z_r <= '0;
            end
            zero_r <= (txs == 21'(signed'(px_r))) && (tys == 21'(signed'(py_r)));
            dt_r <= in_data.elapsed_time;
            it_r <= '0;
            st_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + shy;
            cy_r <= cy_r - shx;
            z_r <= z_r + atan_entry(it_r);
          end else begin
            cx_r <= cx_r - shy;
            cy_r <= cy_r + shx;
            z_r <= z_r - atan_entry(it_r);
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(CordicSteps - 1)) st_r <= S_MUL;
        end
        S_MUL: begin
          lim_r <= 16'((32'(ar_r) * 32'(dt_r)) >> 16);
          step_r <= 16'((32'(lr_r) * 32'(dt_r)) >> 16);
          sq_r <= 42'(adx) * 42'(adx) + 42'(ady) * 42'(ady);
          rt_r <= '0;
          sqi_r <= '0;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          // Bit pair scan: trial subtract (root<<2|1)<<(2k) from the remainder.
          if ({2'b0, sq_r} >= sq_trial) begin
            sq_r <= 42'({2'b0, sq_r} - sq_trial);
            rt_r <= {rt_r[19:0], 1'b1};
          end else begin
            rt_r <= {rt_r[19:0], 1'b0};
          end
          sqi_r <= sqi_r + 5'd1;
          if (sqi_r == 5'd20) st_r <= S_TURN;
        end
        S_TURN: begin
          hd_r <= nh;
          if ({5'd0, step_r} >= rt_r) begin
            px_r <= px_r + dx_r[19:0];
            py_r <= py_r + dy_r[19:0];
            st_r <= S_OUT;
          end else st_r <= S_DIVX;
        end
        S_DIVX: st_r <= S_WX;
        S_WX: if (div_done) begin
          nx_r <= px_r + qs[19:0];
          st_r <= S_DIVY;
        end
        S_DIVY: st_r <= S_WY;
        S_WY: if (div_done) begin
          px_r <= nx_r;
          py_r <= py_r + qs[19:0];
          st_r <= S_OUT;
        end
        S_OUT: begin
          od_r.position_x <= px_r;
          od_r.position_y <= py_r;
          od_r.heading <= hd_r;
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

endmodule
`default_nettype wire

/* design/hpp_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_divider: restoring divider, one quotient bit per cycle
// Divides a 48-bit unsigned numerator by a 24-bit divisor.
// ----------------------------------------------------------------------------
module hpp_divider
  import hpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic [47:0]      quo
);

  logic [47:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[23:0], q_r[47]};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Remainder stays below the divisor, so 25 bits hold the shifted value.
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;

endmodule
`default_nettype wire

/* design/hpp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpp_checker: port-level checks for the pursuit block
// Watches the handshakes and the one-beat-in, one-beat-out ordering.
// ----------------------------------------------------------------------------
module hpp_checker
  import hpp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result waits");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block did not go busy after accepting a beat");

endmodule

bind heading_and_position_pursuit hpp_checker u_hpp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

/* bench/pursuit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pursuit_checker: predicts and checks pursuit updates
// Watches the configuration port and both channels, keeps its own copy of the
// position, heading and rates, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module pursuit_checker
  import hpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          pending_count
);

  logic [15:0]        turn_rate;
  logic [15:0]        travel_rate;
  logic signed [19:0] cur_x;
  logic signed [19:0] cur_y;
  logic [15:0]        cur_heading;
  out_item_t          expected_updates[$];

  function automatic longint shift_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // CORDIC vectoring in a 24-bit angle accumulator, rounded to 16 bits.
  function automatic logic [15:0] bearing_to(longint dx, longint dy);
    longint x;
    longint y;
    longint nx;
    logic [23:0] z;
    x = dx * 256;
    y = dy * 256;
    z = '0;
    if (dx == 0 && dy == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_ACC;
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      if (y > 0) begin
        nx = x + shift_floor(y, i);
        y = y - shift_floor(x, i);
        z = z + atan_entry(i[4:0]);
      end else begin
        nx = x - shift_floor(y, i);
        y = y + shift_floor(x, i);
        z = z - atan_entry(i[4:0]);
      end
      x = nx;
    end
    z = z + 24'd128;
    return z[23:8];
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint a;
    longint q;
    a = (num < 0) ? -num : num;
    q = (a + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  task automatic predict_update(input in_item_t item);
    longint tx, ty, px, py, dx, dy, err, lim, turn, step, span;
    logic [15:0] brg;
    out_item_t res;
    tx = longint'(item.target_x) * 256;
    ty = longint'(item.target_y) * 256;
    px = longint'(cur_x);
    py = longint'(cur_y);
    dx = tx - px;
    dy = ty - py;
    brg = bearing_to(dx, dy);
    err = longint'(16'(brg - cur_heading));
    lim = (longint'(turn_rate) * longint'(item.elapsed_time)) >>> 16;
    step = (longint'(travel_rate) * longint'(item.elapsed_time)) >>> 16;
    span = int_sqrt(dx * dx + dy * dy);
    // Exactly half a turn counts as positive error.
    if (err > 32768) err = err - 65536;
    if (((err < 0) ? -err : err) < lim) turn = err;
    else turn = (err < 0) ? -lim : lim;
    cur_heading = 16'(longint'(cur_heading) + turn);
    if (span <= step) begin
      px = tx;
      py = ty;
    end else begin
      px = px + div_nearest(step * dx, span);
      py = py + div_nearest(step * dy, span);
    end
    cur_x = 20'(px);
    cur_y = 20'(py);
    res.position_x = cur_x;
    res.position_y = cur_y;
    res.heading = cur_heading;
    expected_updates.push_back(res);
  endtask

  always @(posedge clk) begin
    out_item_t exp_item;
    int errs;
    errs = 0;
    if (!rst_n) begin
      turn_rate = ANGULAR_RATE_RESET;
      travel_rate = LINEAR_RATE_RESET;
      cur_x = POS_X_RESET;
      cur_y = POS_Y_RESET;
      cur_heading = '0;
      expected_updates.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ANGULAR_RATE) turn_rate = cfg_data;
        else travel_rate = cfg_data;
      end
      if (in_valid && in_ready) predict_update(in_data);
      if (out_valid && out_ready) begin
        if (expected_updates.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data);
          errs++;
        end else begin
          exp_item = expected_updates.pop_front();
          if (exp_item.position_x !== out_data.position_x) begin
            $error("position_x expected %0d got %0d", exp_item.position_x,
                   out_data.position_x);
            errs++;
          end
          if (exp_item.position_y !== out_data.position_y) begin
            $error("position_y expected %0d got %0d", exp_item.position_y,
                   out_data.position_y);
            errs++;
          end
          if (exp_item.heading !== out_data.heading) begin
            $error("heading expected %0d got %0d", exp_item.heading,
                   out_data.heading);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_updates.size();
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the pursuit block
// Drives targets and elapsed times through several rate settings, with bursty
// input, a stalling receiver and a checker that predicts every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import hpp_pkg::*;

  // The stall limit leaves a wide margin over the worst-case update time
  // plus the longest receiver hold-off.
  localparam int StallLimit = 20000;
  localparam int RandomBeats = 1100;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  int          fail_count;
  int          pending_count;
  int          idle_cycles;
  bit          long_hold;
  bit          hold_done;

  heading_and_position_pursuit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  pursuit_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: a random stall pattern, quiet stretches with no stalls, and one
  // long hold-off while the sender keeps offering beats.
  initial begin
    int mode;
    out_ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Watchdog: any long stretch with no accepted beat ends the run.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Presents one beat and holds it until the block takes it. Valid stays
  // high on return; the caller either sends again or drops it at once.
  task automatic send_beat(input logic signed [11:0] tx, input logic signed [11:0] ty,
                           input logic [15:0] dt);
    in_data.target_x <= tx;
    in_data.target_y <= ty;
    in_data.elapsed_time <= dt;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic send_random(input bit near);
    logic signed [11:0] tx, ty;
    tx = near ? 12'($urandom_range(370, 430)) : 12'($urandom);
    ty = near ? 12'($urandom_range(270, 330)) : 12'($urandom);
    case ($urandom_range(0, 5))
      0: send_beat(tx, ty, 16'($urandom_range(0, 15)));
      1: send_beat(tx, ty, 16'hFFFF - 16'($urandom_range(0, 15)));
      default: send_beat(tx, ty, 16'($urandom));
    endcase
  endtask

  // Stops offering beats and waits until every pending result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic write_rates(input logic [15:0] ang, input logic [15:0] lin);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_ANGULAR_RATE;
    cfg_data <= ang;
    @(posedge clk);
    cfg_index <= REG_LINEAR_RATE;
    cfg_data <= lin;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int burst;
    long_hold = 1'b0;
    hold_done = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ANGULAR_RATE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset rates: zero offset, zero time, extreme
    // targets, exactly half a turn of error and full elapsed time.
    send_beat(12'sd400, 12'sd300, 16'd0);
    send_beat(12'sd400, 12'sd300, 16'd1000);
    send_beat(12'sd500, 12'sd300, 16'd0);
    send_beat(12'sd0, 12'sd300, 16'hFFFF);
    send_beat(-12'sd2048, 12'sd300, 16'hFFFF);
    send_beat(12'sd2047, -12'sd2048, 16'hFFFF);
    send_beat(12'sd2047, 12'sd2047, 16'd40000);
    send_beat(-12'sd2048, -12'sd2048, 16'd1);
    send_beat(12'sd0, 12'sd0, 16'hFFFF);
    // Full rates snap the position and turn toward a point straight behind.
    write_rates(16'hFFFF, 16'hFFFF);
    send_beat(12'sd100, 12'sd100, 16'hFFFF);
    send_beat(12'sd100, 12'sd100, 16'hFFFF);
    send_beat(12'sd50, 12'sd100, 16'hFFFF);
    send_beat(12'sd150, 12'sd100, 16'hFFFF);
    send_beat(12'sd100, -12'sd2048, 16'hFFFF);
    send_beat(12'sd100, 12'sd2047, 16'hFFFF);
    // Zero rates: nothing moves unless already at the target.
    write_rates(16'd0, 16'd0);
    send_beat(-12'sd2048, 12'sd2047, 16'hFFFF);
    send_beat(12'sd100, 12'sd2047, 16'hFFFF);
    write_rates(16'd1, 16'd1);
    send_beat(12'sd2047, 12'sd0, 16'hFFFF);
    send_beat(12'sd1, 12'sd1, 16'd1);

    // Random phases, each at its own setting; the second raises the long
    // receiver hold-off so the block backs up and stalls its input.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_rates(ANGULAR_RATE_RESET, LINEAR_RATE_RESET);
        1: write_rates(16'hFFFF, 16'hFFFF);
        2: write_rates(16'd0, 16'hFFFF);
        3: write_rates(16'hFFFF, 16'd0);
        default: write_rates(16'($urandom), 16'($urandom));
      endcase
      if (phase == 1) long_hold = 1'b1;
      for (int n = 0; n < RandomBeats / 6; ) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && n < RandomBeats / 6; k++, n++)
          send_random($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 300)) @(posedge clk);
        end
      end
      // After the fourth phase the sender pauses here until every result is in.
      if (phase == 3) wait_drained();
    end

    wait_drained();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
